// ----- rtl/core/cusum_pkg.sv -----
// cusum_pkg: types, sizes and codes shared by the axis cumulative sum unit
// depends on: nothing
`timescale 1ns / 1ps

package cusum_pkg;

    localparam int INNER_MAX  = 256;
    localparam int SCAN_MAX   = 4096;
    localparam int SLICE_MAX  = 4096;

    localparam int INNER_W    = 9;
    localparam int SCANLEN_W  = 13;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;

    localparam int LANE_W     = $clog2(INNER_MAX);
    localparam int SCAN_W     = $clog2(SCAN_MAX);
    localparam int SLICE_W    = $clog2(SLICE_MAX);
    localparam int CNT_W      = SLICE_W + 1;
    localparam int PROD_W     = INNER_W + SCANLEN_W;

    localparam int SAMPLE_W   = 32;
    localparam int SUM_W      = 48;

    localparam int OBUF_DEPTH = 3;
    localparam int OBUF_PTR_W = 2;
    localparam int OBUF_CNT_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INNER_LEN,
        CFG_SCAN_LEN,
        CFG_EXCLUSIVE,
        CFG_REVERSE
    } cusum_cfg_idx_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_FWD,
        OP_FILL,
        OP_DRAIN,
        OP_DROP
    } cusum_op_t;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic                       command;
        logic signed [SAMPLE_W-1:0] sample;
    } cusum_in_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    slice_end;
        logic                    overflow_flag;
    } cusum_out_t;

    typedef struct packed {
        logic                       valid;
        cusum_op_t                  op;
        logic [LANE_W-1:0]          lane;
        logic                       first_row;
        logic                       slice_end;
        logic signed [SAMPLE_W-1:0] sample;
    } cusum_lane_req_t;

endpackage

// ----- rtl/core/cusum_seq.sv -----
// cusum_seq: config registers, slice position counters, request decode, slice buffer
// depends on: cusum_pkg
`timescale 1ns / 1ps

module cusum_seq (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [cusum_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cusum_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                 accept,
    input  cusum_pkg::cusum_in_t                 in_data,
    output cusum_pkg::cusum_lane_req_t           req,
    output logic signed [cusum_pkg::SAMPLE_W-1:0] buf_data,
    output logic                                 excl_mode
);
    import cusum_pkg::*;

    logic [INNER_W-1:0]   inner_len_reg;
    logic [SCANLEN_W-1:0] scan_len_reg;
    logic                 excl_reg;
    logic                 rev_reg;

    logic [LANE_W-1:0] lane_index_reg,  lane_index_next;
    logic [SCAN_W-1:0] scan_index_reg,  scan_index_next;
    logic [CNT_W-1:0]  fill_count_reg,  fill_count_next;
    logic [CNT_W-1:0]  drain_index_reg, drain_index_next;
    logic              draining_reg,    draining_next;

    logic [INNER_W-1:0]   inner_eff;
    logic [SCANLEN_W-1:0] scan_eff;
    logic [PROD_W-1:0]    slice_size;
    logic                 too_big;
    logic                 lane_last;
    logic                 scan_last;
    logic                 wrap;
    cusum_op_t            op;

    logic signed [SAMPLE_W-1:0] slice_mem [SLICE_MAX];
    logic signed [SAMPLE_W-1:0] buf_q;

    // clamp registers into legal ranges
    always_comb begin
        if (inner_len_reg == '0) begin
            inner_eff = INNER_W'(1);
        end else if (inner_len_reg > INNER_W'(INNER_MAX)) begin
            inner_eff = INNER_W'(INNER_MAX);
        end else begin
            inner_eff = inner_len_reg;
        end
        if (scan_len_reg == '0) begin
            scan_eff = SCANLEN_W'(1);
        end else if (scan_len_reg > SCANLEN_W'(SCAN_MAX)) begin
            scan_eff = SCANLEN_W'(SCAN_MAX);
        end else begin
            scan_eff = scan_len_reg;
        end
    end

    assign slice_size = {{SCANLEN_W{1'b0}}, inner_eff} * {{INNER_W{1'b0}}, scan_eff};
    assign too_big    = slice_size > PROD_W'(SLICE_MAX);
    assign lane_last  = ({1'b0, lane_index_reg} + INNER_W'(1)) >= inner_eff;
    assign scan_last  = ({1'b0, scan_index_reg} + SCANLEN_W'(1)) >= scan_eff;
    assign wrap       = lane_last && scan_last;

    always_comb begin
        if (in_data.command == CMD_DRAIN) begin
            op = draining_reg ? OP_DRAIN : OP_NONE;
        end else if (draining_reg) begin
            op = OP_DROP;
        end else if (!rev_reg) begin
            op = OP_FWD;
        end else if (too_big) begin
            op = OP_DROP;
        end else begin
            op = OP_FILL;
        end
    end

    always_comb begin
        req.valid     = accept;
        req.op        = op;
        req.lane      = lane_index_reg;
        req.first_row = (scan_index_reg == '0);
        req.slice_end = wrap && (op == OP_FWD || op == OP_DRAIN);
        req.sample    = in_data.sample;
    end

    always_comb begin
        lane_index_next  = lane_index_reg;
        scan_index_next  = scan_index_reg;
        fill_count_next  = fill_count_reg;
        drain_index_next = drain_index_reg;
        draining_next    = draining_reg;
        if (accept && (op == OP_FWD || op == OP_FILL || op == OP_DRAIN)) begin
            if (lane_last) begin
                lane_index_next = '0;
                scan_index_next = scan_last ? '0 : scan_index_reg + 1'b1;
            end else begin
                lane_index_next = lane_index_reg + 1'b1;
            end
            if (op == OP_FILL) begin
                fill_count_next = fill_count_reg + 1'b1;
                if (wrap) begin
                    draining_next    = 1'b1;
                    drain_index_next = '0;
                end
            end else if (op == OP_DRAIN) begin
                drain_index_next = drain_index_reg + 1'b1;
                if (wrap) begin
                    draining_next    = 1'b0;
                    fill_count_next  = '0;
                    drain_index_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inner_len_reg   <= INNER_W'(1);
            scan_len_reg    <= SCANLEN_W'(1);
            excl_reg        <= 1'b0;
            rev_reg         <= 1'b0;
            lane_index_reg  <= '0;
            scan_index_reg  <= '0;
            fill_count_reg  <= '0;
            drain_index_reg <= '0;
            draining_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cusum_cfg_idx_t'(cfg_index))
                CFG_INNER_LEN: inner_len_reg <= cfg_data[INNER_W-1:0];
                CFG_SCAN_LEN:  scan_len_reg  <= cfg_data[SCANLEN_W-1:0];
                CFG_EXCLUSIVE: excl_reg      <= cfg_data[0];
                CFG_REVERSE:   rev_reg       <= cfg_data[0];
                default:       excl_reg      <= excl_reg;
            endcase
            // any write restarts the slice
            lane_index_reg  <= '0;
            scan_index_reg  <= '0;
            fill_count_reg  <= '0;
            drain_index_reg <= '0;
            draining_reg    <= 1'b0;
        end else begin
            lane_index_reg  <= lane_index_next;
            scan_index_reg  <= scan_index_next;
            fill_count_reg  <= fill_count_next;
            drain_index_reg <= drain_index_next;
            draining_reg    <= draining_next;
        end
    end

    // slice buffer
    always_ff @(posedge aclk) begin
        if (accept && op == OP_FILL) begin
            slice_mem[fill_count_reg[SLICE_W-1:0]] <= in_data.sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && op == OP_DRAIN) begin
            buf_q <= slice_mem[drain_index_reg[SLICE_W-1:0]];
        end
    end

    assign buf_data  = buf_q;
    assign excl_mode = excl_reg;

    a_drain_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        draining_reg |-> drain_index_reg < fill_count_reg)
        else $error("drain index ran past the filled slice");

    a_drain_rev: assert property (@(posedge aclk) disable iff (!aresetn)
        draining_reg |-> rev_reg)
        else $error("draining outside reverse mode");

    a_lane_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, lane_index_reg} < inner_eff)
        else $error("lane index beyond inner length");

endmodule

// ----- rtl/core/cusum_lane.sv -----
// cusum_lane: lane prefix/total memories, read-modify-write stage with bypass
// depends on: cusum_pkg
`timescale 1ns / 1ps

module cusum_lane (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  cusum_pkg::cusum_lane_req_t            req,
    input  logic signed [cusum_pkg::SAMPLE_W-1:0] buf_data,
    input  logic                                  excl_mode,
    output logic                                  busy,
    output logic                                  push,
    output cusum_pkg::cusum_out_t                 push_data
);
    import cusum_pkg::*;

    logic signed [SUM_W-1:0] prefix_mem [INNER_MAX];
    logic signed [SUM_W-1:0] total_mem  [INNER_MAX];

    cusum_lane_req_t         st1_reg;
    logic signed [SUM_W-1:0] prefix_q;
    logic signed [SUM_W-1:0] total_q;
    logic                    byp_p_hit_reg;
    logic                    byp_t_hit_reg;
    logic signed [SUM_W-1:0] byp_p_data_reg;
    logic signed [SUM_W-1:0] byp_t_data_reg;

    logic signed [SAMPLE_W-1:0] x32;
    logic signed [SUM_W-1:0]    x48;
    logic signed [SUM_W-1:0]    prefix;
    logic signed [SUM_W-1:0]    total;
    logic signed [SUM_W-1:0]    total_base;
    logic signed [SUM_W-1:0]    new_prefix;
    logic signed [SUM_W-1:0]    new_total;
    logic                       wr_prefix;
    logic                       wr_total;
    logic                       rd_prefix;
    logic                       rd_total;

    assign rd_prefix = req.valid && (req.op == OP_FWD || req.op == OP_DRAIN);
    assign rd_total  = req.valid && (req.op == OP_FILL || req.op == OP_DRAIN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_reg       <= '0;
            byp_p_hit_reg <= 1'b0;
            byp_t_hit_reg <= 1'b0;
        end else begin
            st1_reg       <= req;
            // same lane written this edge: memory read is stale
            byp_p_hit_reg <= rd_prefix && wr_prefix && (st1_reg.lane == req.lane);
            byp_t_hit_reg <= rd_total && wr_total && (st1_reg.lane == req.lane);
        end
    end

    always_ff @(posedge aclk) begin
        byp_p_data_reg <= new_prefix;
        byp_t_data_reg <= new_total;
    end

    always_ff @(posedge aclk) begin
        if (rd_prefix) begin
            prefix_q <= prefix_mem[req.lane];
        end
        if (wr_prefix) begin
            prefix_mem[st1_reg.lane] <= new_prefix;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_total) begin
            total_q <= total_mem[req.lane];
        end
        if (wr_total) begin
            total_mem[st1_reg.lane] <= new_total;
        end
    end

    always_comb begin
        x32        = (st1_reg.op == OP_DRAIN) ? buf_data : st1_reg.sample;
        x48        = {{(SUM_W-SAMPLE_W){x32[SAMPLE_W-1]}}, x32};
        prefix     = st1_reg.first_row ? '0 : (byp_p_hit_reg ? byp_p_data_reg : prefix_q);
        total      = byp_t_hit_reg ? byp_t_data_reg : total_q;
        total_base = st1_reg.first_row ? '0 : total;
        new_prefix = prefix + x48;
        new_total  = total_base + x48;
        wr_prefix  = st1_reg.valid && (st1_reg.op == OP_FWD || st1_reg.op == OP_DRAIN);
        wr_total   = st1_reg.valid && (st1_reg.op == OP_FILL);
    end

    always_comb begin
        push                    = 1'b0;
        push_data.sum           = '0;
        push_data.slice_end     = st1_reg.slice_end;
        push_data.overflow_flag = 1'b0;
        case (st1_reg.op)
            OP_FWD: begin
                push          = st1_reg.valid;
                push_data.sum = excl_mode ? prefix : new_prefix;
            end
            OP_DRAIN: begin
                push          = st1_reg.valid;
                push_data.sum = excl_mode ? (total - prefix - x48) : (total - prefix);
            end
            OP_DROP: begin
                push                    = st1_reg.valid;
                push_data.slice_end     = 1'b0;
                push_data.overflow_flag = 1'b1;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    assign busy = st1_reg.valid;

    a_bypass_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (byp_p_hit_reg || byp_t_hit_reg) |-> $past(st1_reg.valid) && st1_reg.valid)
        else $error("bypass without a preceding write");

    a_one_mem_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_prefix && wr_total))
        else $error("both lane memories written by one request");

    a_bypass_lane: assert property (@(posedge aclk) disable iff (!aresetn)
        byp_p_hit_reg |-> st1_reg.lane == $past(st1_reg.lane))
        else $error("prefix bypass for a different lane");

endmodule

// ----- rtl/core/cusum_obuf.sv -----
// cusum_obuf: result queue decoupling the result channel from the lane stage
// depends on: cusum_pkg
`timescale 1ns / 1ps

module cusum_obuf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  cusum_pkg::cusum_out_t push_data,
    input  logic                  inflight,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output cusum_pkg::cusum_out_t m_data
);
    import cusum_pkg::*;

    cusum_out_t              q_mem [OBUF_DEPTH];
    logic [OBUF_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OBUF_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OBUF_CNT_W-1:0]   count_reg,  count_next;
    logic                    pop;
    logic [OBUF_CNT_W:0]     reserved;

    assign pop      = m_valid && m_ready;
    assign m_valid  = (count_reg != '0);
    assign m_data   = q_mem[rd_ptr_reg];
    // room for the request in flight plus the next one
    assign reserved = {1'b0, count_reg} + {{OBUF_CNT_W{1'b0}}, inflight};
    assign s_ready  = reserved < (OBUF_CNT_W+1)'(OBUF_DEPTH);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == OBUF_PTR_W'(OBUF_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == OBUF_PTR_W'(OBUF_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> count_reg != OBUF_CNT_W'(OBUF_DEPTH))
        else $error("result queue overrun");

    a_push_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && count_reg == '0) |=> m_valid)
        else $error("pushed result not presented");

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_ptr_reg < OBUF_PTR_W'(OBUF_DEPTH) && rd_ptr_reg < OBUF_PTR_W'(OBUF_DEPTH))
        else $error("queue pointer out of range");

endmodule

// ----- rtl/core/axis_cumulative_sum_unit.sv -----
// Cumulative sum along one tensor axis, forward or reverse, inclusive or exclusive.
// One request per clock: a request is accepted every cycle that the result queue has
// room, the lane sum is read from a registered-read RAM and written back the next
// cycle with a bypass for back-to-back requests to the same lane; each result goes to
// the result queue on m_. Reverse mode buffers a whole slice (up to 4096 elements)
// and drain requests then return one suffix sum each. No clearing pass after reset.
// depends on: cusum_pkg, cusum_seq, cusum_lane, cusum_obuf
`timescale 1ns / 1ps

module axis_cumulative_sum_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  cusum_pkg::cusum_in_t               s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output cusum_pkg::cusum_out_t              m_data,
    input  logic                               cfg_wr_en,
    input  logic [cusum_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cusum_pkg::CFG_W-1:0]        cfg_data
);
    import cusum_pkg::*;

    logic                       accept;
    cusum_lane_req_t            req;
    logic signed [SAMPLE_W-1:0] buf_data;
    logic                       excl_mode;
    logic                       busy;
    logic                       push;
    cusum_out_t                 push_data;

    assign accept = s_valid && s_ready;

    cusum_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .in_data   (s_data),
        .req       (req),
        .buf_data  (buf_data),
        .excl_mode (excl_mode)
    );

    cusum_lane u_lane (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .buf_data  (buf_data),
        .excl_mode (excl_mode),
        .busy      (busy),
        .push      (push),
        .push_data (push_data)
    );

    cusum_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .inflight  (busy),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
